@@ rtl/dfpe_pkg.sv @@
`default_nettype none

package dfpe_pkg;

  localparam int NUM_CH      = 4;
  localparam int THR_W       = 11;
  localparam int WORD_W      = THR_W + 1;
  localparam int FRAME_W     = 16;
  localparam int SUM_W       = 4;
  localparam int WIDTH_W     = 16;
  localparam int DATA_SLOTS  = 16;
  localparam int FRAME_SLOTS = 18;
  localparam int SLOT_W      = 5;
  localparam int Q_DEPTH     = 2;
  localparam int Q_PTR_W     = $clog2(Q_DEPTH);
  localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);
  localparam int CFG_IDX_W   = 8;

  localparam logic [WIDTH_W-1:0] ONE_WIDTH_RST  = 16'd14;
  localparam logic [WIDTH_W-1:0] ZERO_WIDTH_RST = 16'd7;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_ONE_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_WIDTH = 8'd1;

  typedef logic [FRAME_W-1:0]             frame_t;
  typedef frame_t [NUM_CH-1:0]            frame_set_t;
  typedef logic [WIDTH_W-1:0]             width_t;

  typedef struct packed {
    logic       valid;
    frame_set_t frames;
  } frame_push_t;

  typedef struct packed {
    logic       valid;
    frame_set_t frames;
  } frame_head_t;

endpackage

`default_nettype wire

@@ rtl/dfpe_if.sv @@
`default_nettype none

interface dfpe_cmd_if;
  logic        valid;
  logic        ready;
  logic [10:0] throttle_ch0;
  logic [10:0] throttle_ch1;
  logic [10:0] throttle_ch2;
  logic [10:0] throttle_ch3;
  logic        telemetry;

  modport source (output valid, throttle_ch0, throttle_ch1, throttle_ch2, throttle_ch3,
                  telemetry, input ready);
  modport sink   (input valid, throttle_ch0, throttle_ch1, throttle_ch2, throttle_ch3,
                  telemetry, output ready);
endinterface

interface dfpe_slot_if;
  logic        valid;
  logic        ready;
  logic [15:0] width_ch0;
  logic [15:0] width_ch1;
  logic [15:0] width_ch2;
  logic [15:0] width_ch3;
  logic [4:0]  slot_index;
  logic        last_slot;

  modport source (output valid, width_ch0, width_ch1, width_ch2, width_ch3, slot_index,
                  last_slot, input ready);
  modport sink   (input valid, width_ch0, width_ch1, width_ch2, width_ch3, slot_index,
                  last_slot, output ready);
endinterface

interface dfpe_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/dfpe_front.sv @@
`default_nettype none

module dfpe_front
  import dfpe_pkg::*;
(
  dfpe_cmd_if.sink    cmd,
  input  logic        full_i,
  output frame_push_t push_o
);

  function automatic frame_t build_frame(input logic [THR_W-1:0] thr, input logic tel);
    logic [WORD_W-1:0] word;
    logic [SUM_W-1:0]  sum;
    word = {thr, tel};
    sum  = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, sum};
  endfunction

  assign cmd.ready = !full_i;

  always_comb begin
    push_o.valid     = cmd.valid && !full_i;
    push_o.frames[0] = build_frame(cmd.throttle_ch0, cmd.telemetry);
    push_o.frames[1] = build_frame(cmd.throttle_ch1, cmd.telemetry);
    push_o.frames[2] = build_frame(cmd.throttle_ch2, cmd.telemetry);
    push_o.frames[3] = build_frame(cmd.throttle_ch3, cmd.telemetry);
  end

endmodule

`default_nettype wire

@@ rtl/dfpe_queue.sv @@
`default_nettype none

module dfpe_queue
  import dfpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_push_t push_i,
  output logic        full_o,
  output frame_head_t head_o,
  input  logic        pop_i
);

  frame_set_t         mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CNT_W-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o       = (cnt_q == Q_CNT_W'(Q_DEPTH));
  assign head_o.valid = (cnt_q != '0);
  assign head_o.frames = mem_q[rd_ptr_q];

  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.frames;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dfpe_back.sv @@
`default_nettype none

module dfpe_back
  import dfpe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  frame_head_t head_i,
  output logic        pop_o,
  input  width_t      one_width_i,
  input  width_t      zero_width_i,
  dfpe_slot_if.source slot
);

  frame_set_t            shift_q, shift_d;
  logic [SLOT_W-1:0]     cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  out_valid_q, out_valid_d;
  width_t [NUM_CH-1:0]   width_q, width_d;
  logic [SLOT_W-1:0]     idx_q;
  logic                  last_q;
  logic                  emit, last, data_slot, load;

  assign emit      = busy_q && (!out_valid_q || slot.ready);
  assign last      = (cnt_q == SLOT_W'(FRAME_SLOTS - 1));
  assign data_slot = (cnt_q < SLOT_W'(DATA_SLOTS));
  // next frame set loads in the same cycle the last slot goes out
  assign load      = head_i.valid && (!busy_q || (emit && last));
  assign pop_o     = load;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    shift_d     = shift_q;
    out_valid_d = out_valid_q;
    if (slot.ready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
      cnt_d       = last ? '0 : cnt_q + 1'b1;
      if (last) begin
        busy_d = 1'b0;
      end
      if (data_slot) begin
        for (int c = 0; c < NUM_CH; c++) begin
          shift_d[c] = {shift_q[c][FRAME_W-2:0], 1'b0};
        end
      end
    end
    if (load) begin
      busy_d  = 1'b1;
      shift_d = head_i.frames;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      if (!data_slot) begin
        width_d[c] = '0;
      end else if (shift_q[c][FRAME_W-1]) begin
        width_d[c] = one_width_i;
      end else begin
        width_d[c] = zero_width_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (emit) begin
      width_q <= width_d;
      idx_q   <= cnt_q;
      last_q  <= last;
    end
  end

  assign slot.valid      = out_valid_q;
  assign slot.width_ch0  = width_q[0];
  assign slot.width_ch1  = width_q[1];
  assign slot.width_ch2  = width_q[2];
  assign slot.width_ch3  = width_q[3];
  assign slot.slot_index = idx_q;
  assign slot.last_slot  = last_q;

endmodule

`default_nettype wire

@@ rtl/dshot_frame_pulse_encoder.sv @@
// A command passes through the frame queue, the sequencer's shift register and the slot register.
// The sequencer emits one slot per cycle while the slot receiver is ready, 18 slots per command.
// A two-entry frame queue takes commands while the sequencer is still emitting slots.
// Reset (async, active low) empties the queue, idles the sequencer, and loads the
// bit widths with 14 (one) and 7 (zero).
`default_nettype none

module dshot_frame_pulse_encoder
  import dfpe_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  dfpe_cmd_if.sink    cmd,
  dfpe_slot_if.source slot,
  dfpe_cfg_if.sink    cfg
);

  width_t      one_width_q;
  width_t      zero_width_q;
  frame_push_t push;
  frame_head_t head;
  logic        full;
  logic        pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_width_q  <= ONE_WIDTH_RST;
      zero_width_q <= ZERO_WIDTH_RST;
    end else if (cfg.valid) begin
      if (cfg.index == REG_ONE_WIDTH) begin
        one_width_q <= cfg.data;
      end else if (cfg.index == REG_ZERO_WIDTH) begin
        zero_width_q <= cfg.data;
      end
    end
  end

  dfpe_front u_front (
    .cmd    (cmd),
    .full_i (full),
    .push_o (push)
  );

  dfpe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (full),
    .head_o (head),
    .pop_i  (pop)
  );

  dfpe_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .one_width_i  (one_width_q),
    .zero_width_i (zero_width_q),
    .slot         (slot)
  );

endmodule

`default_nettype wire

@@ test/dfpe_frame_checker.sv @@
`default_nettype none

module dfpe_frame_checker
  import dfpe_pkg::*;
(
  input  wire  clk_i,
  input  wire  rst_ni,
  dfpe_cmd_if  cmd,
  dfpe_slot_if slot,
  dfpe_cfg_if  cfg,
  output int   mismatch_count_o,
  output int   pending_slots_o
);

  typedef struct packed {
    width_t [NUM_CH-1:0] width;
    logic [SLOT_W-1:0]   index;
    logic                last;
  } slot_beat_t;

  width_t     one_width  = ONE_WIDTH_RST;
  width_t     zero_width = ZERO_WIDTH_RST;
  slot_beat_t expected_slots_q[$];
  int         mismatches = 0;

  always @(posedge clk_i) begin : monitor
    logic [THR_W-1:0]  throttle [NUM_CH];
    logic [WORD_W-1:0] word;
    frame_t            frame [NUM_CH];
    slot_beat_t        beat;
    slot_beat_t        got;

    if (!rst_ni) begin
      one_width  = ONE_WIDTH_RST;
      zero_width = ZERO_WIDTH_RST;
      expected_slots_q.delete();
    end else begin
      // writes to any other index are dropped by the block
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_ONE_WIDTH) begin
          one_width = cfg.data;
        end else if (cfg.index == REG_ZERO_WIDTH) begin
          zero_width = cfg.data;
        end
      end

      if (cmd.valid && cmd.ready) begin
        throttle[0] = cmd.throttle_ch0;
        throttle[1] = cmd.throttle_ch1;
        throttle[2] = cmd.throttle_ch2;
        throttle[3] = cmd.throttle_ch3;
        for (int c = 0; c < NUM_CH; c++) begin
          word     = {throttle[c], cmd.telemetry};
          frame[c] = {word, word[3:0] ^ word[7:4] ^ word[11:8]};
        end
        for (int s = 0; s < FRAME_SLOTS; s++) begin
          for (int c = 0; c < NUM_CH; c++) begin
            if (s < DATA_SLOTS) begin
              beat.width[c] = frame[c][FRAME_W-1-s] ? one_width : zero_width;
            end else begin
              beat.width[c] = '0;
            end
          end
          beat.index = SLOT_W'(s);
          beat.last  = (s == FRAME_SLOTS - 1);
          expected_slots_q.push_back(beat);
        end
      end

      if (slot.valid && slot.ready) begin
        got.width = {slot.width_ch3, slot.width_ch2, slot.width_ch1, slot.width_ch0};
        got.index = slot.slot_index;
        got.last  = slot.last_slot;
        if (expected_slots_q.size() == 0) begin
          $display("%0t: unexpected slot, got index %0d", $time, got.index);
          mismatches++;
        end else begin
          beat = expected_slots_q.pop_front();
          for (int c = 0; c < NUM_CH; c++) begin
            if (got.width[c] !== beat.width[c]) begin
              $display("%0t: slot %0d width_ch%0d expected %0d got %0d",
                       $time, beat.index, c, beat.width[c], got.width[c]);
              mismatches++;
            end
          end
          if (got.index !== beat.index) begin
            $display("%0t: slot_index expected %0d got %0d", $time, beat.index, got.index);
            mismatches++;
          end
          if (got.last !== beat.last) begin
            $display("%0t: slot %0d last_slot expected %0b got %0b",
                     $time, beat.index, beat.last, got.last);
            mismatches++;
          end
        end
      end
    end

    mismatch_count_o <= mismatches;
    pending_slots_o  <= expected_slots_q.size();
  end

endmodule

`default_nettype wire

@@ test/tb_dshot_frame_pulse_encoder.sv @@
`default_nettype none

module tb_dshot_frame_pulse_encoder;
  import dfpe_pkg::*;

  localparam int IDLE_LIMIT = 1000;
  localparam int RAND_PER_PHASE = 60;

  logic clk_i = 1'b0;
  logic rst_ni;
  int   mismatch_count;
  int   pending_slots;
  int   idle_cycles = 0;
  bit   cmd_calm = 1'b0;

  always #5 clk_i = ~clk_i;

  dfpe_cmd_if  cmd_bus ();
  dfpe_slot_if slot_bus ();
  dfpe_cfg_if  cfg_bus ();

  dshot_frame_pulse_encoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd    (cmd_bus),
    .slot   (slot_bus),
    .cfg    (cfg_bus)
  );

  dfpe_frame_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd              (cmd_bus),
    .slot             (slot_bus),
    .cfg              (cfg_bus),
    .mismatch_count_o (mismatch_count),
    .pending_slots_o  (pending_slots)
  );

  // no-progress watchdog over all three channels
  always @(posedge clk_i) begin
    if ((cmd_bus.valid && cmd_bus.ready) || (slot_bus.valid && slot_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // slot receiver: mostly short stalls, a few long ones, calm stretches with none
  initial begin : slot_sink
    int stall_left;
    bit calm;
    stall_left = 0;
    calm = 1'b0;
    slot_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 299) == 0) calm = !calm;
      if (stall_left > 0) begin
        stall_left--;
        slot_bus.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        slot_bus.ready <= 1'b0;
      end else begin
        slot_bus.ready <= 1'b1;
      end
    end
  end

  task automatic push_command(input logic [THR_W-1:0] t0, t1, t2, t3, input logic telem);
    int gap;
    @(negedge clk_i);
    cmd_bus.valid        <= 1'b1;
    cmd_bus.throttle_ch0 <= t0;
    cmd_bus.throttle_ch1 <= t1;
    cmd_bus.throttle_ch2 <= t2;
    cmd_bus.throttle_ch3 <= t3;
    cmd_bus.telemetry    <= telem;
    do @(posedge clk_i); while (!(cmd_bus.valid && cmd_bus.ready));
    if (cmd_calm || $urandom_range(0, 99) < 55) begin
      gap = 0;
    end else if ($urandom_range(0, 9) < 8) begin
      gap = $urandom_range(1, 3);
    end else begin
      gap = $urandom_range(10, 50);
    end
    if (gap > 0) begin
      @(negedge clk_i);
      cmd_bus.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input width_t value);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk_i); while (!(cfg_bus.valid && cfg_bus.ready));
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // drop the command request and wait until every predicted slot has come out
  task automatic drain_slots();
    @(negedge clk_i);
    cmd_bus.valid <= 1'b0;
    while (pending_slots != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  function automatic logic [THR_W-1:0] pick_throttle();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return THR_W'($urandom_range(0, 2047));
    endcase
  endfunction

  initial begin : stimulus
    logic [THR_W-1:0] walk;
    width_t           one_set  [6];
    width_t           zero_set [6];

    one_set  = '{16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF, 16'h0001, 16'd14};
    zero_set = '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000, 16'd7};

    cmd_bus.valid        = 1'b0;
    cmd_bus.throttle_ch0 = '0;
    cmd_bus.throttle_ch1 = '0;
    cmd_bus.throttle_ch2 = '0;
    cmd_bus.throttle_ch3 = '0;
    cmd_bus.telemetry    = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.index        = '0;
    cfg_bus.data         = '0;
    rst_ni               = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed, reset widths; back-to-back so the frame queue fills up
    cmd_calm = 1'b1;
    push_command('0, '0, '0, '0, 1'b0);
    push_command('1, '1, '1, '1, 1'b1);
    push_command('0, '1, 11'h555, 11'h2AA, 1'b0);
    push_command(11'h2AA, 11'h555, '1, '0, 1'b1);
    push_command('0, '0, '0, '0, 1'b1);
    push_command('1, '1, '1, '1, 1'b0);
    walk = 11'd1;
    for (int i = 0; i < THR_W; i += 2) begin
      push_command(walk << i, walk << (i + 1), ~(walk << i), 11'd48 + THR_W'(i), i[1]);
    end
    cmd_calm = 1'b0;
    push_command(11'd48, 11'd47, 11'd1, 11'd1000, 1'b1);
    drain_slots();

    // each phase reprograms both widths, plus a write the block must drop
    for (int p = 0; p < 6; p++) begin
      write_reg((p == 0) ? '1 : CFG_IDX_W'($urandom_range(REG_ZERO_WIDTH + 1, 255)),
                width_t'($urandom_range(0, 65535)));
      write_reg(REG_ONE_WIDTH, (p == 2) ? width_t'($urandom_range(0, 65535)) : one_set[p]);
      write_reg(REG_ZERO_WIDTH, (p == 2) ? width_t'($urandom_range(0, 65535)) : zero_set[p]);
      cmd_calm = (p == 3);
      for (int i = 0; i < ((p == 5) ? 20 : RAND_PER_PHASE); i++) begin
        push_command(pick_throttle(), pick_throttle(), pick_throttle(), pick_throttle(),
                     1'($urandom_range(0, 1)));
      end
      drain_slots();
    end

    repeat (10) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
